[rtl/salc_pkg.sv]
// -----------------------------------------------------------------------------
// salc_pkg
// Shared widths, codes and types of the set-associative LRU cache lookup.
// -----------------------------------------------------------------------------
package salc_pkg;

   localparam int ADDR_W         = 64;
   localparam int TAG_W          = 62;
   localparam int KIND_W         = 2;
   localparam int OUT_WAY_W      = 2;
   localparam int RSP_DATA_W     = 8;

   localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_STORE = 2'd1;

   localparam int SET_BITS_W     = 4;
   localparam int BLOCK_BITS_W   = 5;
   localparam int WAYS_USE_W     = 3;
   localparam int MAX_BLOCK_BITS = 16;

   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 5;

   localparam logic [CSR_INDEX_W-1:0] CSR_SET_BITS    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_BITS  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAYS_IN_USE = 2'd2;

   localparam logic [SET_BITS_W-1:0]   SET_BITS_RST    = 4'd4;
   localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST  = 5'd4;
   localparam logic [WAYS_USE_W-1:0]   WAYS_IN_USE_RST = 3'd4;

   typedef struct packed {
      logic                 hit;
      logic                 evicted;
      logic [OUT_WAY_W-1:0] way;
   } lookup_result_type;

endpackage

[rtl/salc_lookup.sv]
// -----------------------------------------------------------------------------
// salc_lookup
// Tag match, fill or victim choice and true LRU rank update for one set.
// -----------------------------------------------------------------------------
module salc_lookup
   import salc_pkg::*;
#(
   parameter int WAYS = 4,
   localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1
) (
   input  logic [WAYS-1:0]              use_mask,
   input  logic [TAG_W-1:0]             tag,
   input  logic [WAYS-1:0]              row_valid,
   input  logic [WAYS-1:0][TAG_W-1:0]   row_tag,
   input  logic [WAYS-1:0][RANK_W-1:0]  row_rank,
   output lookup_result_type            result,
   output logic [WAYS-1:0]              new_valid,
   output logic [WAYS-1:0][TAG_W-1:0]   new_tag,
   output logic [WAYS-1:0][RANK_W-1:0]  new_rank
);

   localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(WAYS - 1);

   logic [WAYS-1:0]   match;
   logic              hit;
   logic [RANK_W-1:0] hit_way;
   logic              found_empty;
   logic [RANK_W-1:0] empty_way;
   logic [RANK_W-1:0] best_rank;
   logic [RANK_W-1:0] victim_way;
   logic [RANK_W-1:0] sel_way;

   always_comb begin
      hit         = 1'b0;
      hit_way     = '0;
      found_empty = 1'b0;
      empty_way   = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         match[w] = use_mask[w] && row_valid[w] && (row_tag[w] == tag);
         if (match[w]) begin
            hit     = 1'b1;
            hit_way = RANK_W'(w);
         end
         if (use_mask[w] && !row_valid[w]) begin
            found_empty = 1'b1;
            empty_way   = RANK_W'(w);
         end
      end
   end

   always_comb begin
      best_rank  = '0;
      victim_way = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (use_mask[w] && (row_rank[w] > best_rank)) begin
            best_rank  = row_rank[w];
            victim_way = RANK_W'(w);
         end
      end
   end

   always_comb begin
      if (hit) begin
         sel_way = hit_way;
      end else if (found_empty) begin
         sel_way = empty_way;
      end else begin
         sel_way = victim_way;
      end
   end

   // age the valid ways younger than the touched one (on a miss, every valid way)
   always_comb begin
      new_valid = row_valid;
      new_tag   = row_tag;
      new_rank  = row_rank;
      for (int v = 0; v < WAYS; v++) begin
         if (use_mask[v] && (RANK_W'(v) != sel_way) && row_valid[v] &&
             (!hit || (row_rank[v] < row_rank[sel_way])) &&
             (row_rank[v] != RANK_MAX)) begin
            new_rank[v] = row_rank[v] + 1'b1;
         end
      end
      new_valid[sel_way] = 1'b1;
      new_tag[sel_way]   = tag;
      new_rank[sel_way]  = '0;
   end

   assign result.hit     = hit;
   assign result.evicted = !hit && !found_empty;
   assign result.way     = OUT_WAY_W'(sel_way);

endmodule

[rtl/set_assoc_lru_cache_lookup_core.sv]
// -----------------------------------------------------------------------------
// set_assoc_lru_cache_lookup_core
// Set-associative cache lookup with true LRU replacement, one access per cycle when not stalled.
// -----------------------------------------------------------------------------
// Takes one access word per cycle when not stalled (load, store or instruction
// fetch); loads and stores give one result word each, other kinds none. The
// path is input register, set memory read, lookup and write-back into the
// result register; a one-entry bypass forwards a set written in the same cycle
// it is read, so back-to-back accesses to one set keep the rate of one word per
// cycle when not stalled. After reset a clearing pass walks all 2**MAX_SET_BITS
// sets, one set per cycle, while req_tready stays low; configuration writes are
// taken at any time and must only come while idle.
// -----------------------------------------------------------------------------
module set_assoc_lru_cache_lookup_core
   import salc_pkg::*;
#(
   parameter int MAX_SET_BITS = 8,
   parameter int WAYS         = 4
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [ADDR_W-1:0]      req_tdata,   // address[63:0]
   input  logic [KIND_W-1:0]      req_tuser,   // kind[1:0]

   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // hit, evicted, way[1:0], zero pad
   output logic                   rsp_tuser,   // is_store

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int RANK_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int NUM_SETS = 1 << MAX_SET_BITS;
   localparam int SHIFT_W  = 6;

   logic [SET_BITS_W-1:0]   set_bits_ff,   set_bits_in;
   logic [BLOCK_BITS_W-1:0] block_bits_ff, block_bits_in;
   logic [WAYS_USE_W-1:0]   ways_use_ff,   ways_use_in;

   logic                    clearing_ff, clearing_in;
   logic [MAX_SET_BITS-1:0] clr_idx_ff,  clr_idx_in;

   logic                    a_valid_ff, a_valid_in;
   logic [ADDR_W-1:0]       a_addr_ff;
   logic                    a_store_ff;

   logic                    b_valid_ff, b_valid_in;
   logic [TAG_W-1:0]        b_tag_ff;
   logic [MAX_SET_BITS-1:0] b_set_ff;
   logic                    b_store_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   lookup_result_type       rsp_res_ff;
   logic                    rsp_store_ff;

   logic [WAYS-1:0]              rd_valid_ff, fwd_valid_ff;
   logic [WAYS-1:0][TAG_W-1:0]   rd_tag_ff,   fwd_tag_ff;
   logic [WAYS-1:0][RANK_W-1:0]  rd_rank_ff,  fwd_rank_ff;
   logic                         fwd_sel_ff,  fwd_sel_in;

   logic [WAYS-1:0]              mem_valid [NUM_SETS];
   logic [WAYS-1:0][TAG_W-1:0]   mem_tag   [NUM_SETS];
   logic [WAYS-1:0][RANK_W-1:0]  mem_rank  [NUM_SETS];

   logic [SET_BITS_W-1:0]   set_eff;
   logic [BLOCK_BITS_W-1:0] blk_eff;
   logic [SHIFT_W-1:0]      tag_shift;
   logic [MAX_SET_BITS-1:0] set_mask;
   logic [ADDR_W-1:0]       addr_blk;
   logic [MAX_SET_BITS-1:0] set_a;
   logic [TAG_W-1:0]        tag_a;
   logic [WAYS-1:0]         use_mask;

   logic                    accept;
   logic                    is_data;
   logic                    a_move;
   logic                    b_ready;
   logic                    b_write;
   logic                    c_ready;

   logic [WAYS-1:0]              row_valid, new_valid;
   logic [WAYS-1:0][TAG_W-1:0]   row_tag,   new_tag;
   logic [WAYS-1:0][RANK_W-1:0]  row_rank,  new_rank;
   lookup_result_type            result;

   logic                    mem_we;
   logic [MAX_SET_BITS-1:0] wr_set;
   logic [WAYS-1:0]         wr_valid;

   // configuration
   assign csr_ready = 1'b1;

   always_comb begin
      set_bits_in   = set_bits_ff;
      block_bits_in = block_bits_ff;
      ways_use_in   = ways_use_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SET_BITS:    set_bits_in   = csr_data[SET_BITS_W-1:0];
            CSR_BLOCK_BITS:  block_bits_in = csr_data[BLOCK_BITS_W-1:0];
            CSR_WAYS_IN_USE: ways_use_in   = csr_data[WAYS_USE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (set_bits_ff == '0) begin
         set_eff = SET_BITS_W'(1);
      end else if (int'(set_bits_ff) > MAX_SET_BITS) begin
         set_eff = SET_BITS_W'(MAX_SET_BITS);
      end else begin
         set_eff = set_bits_ff;
      end
      if (block_bits_ff == '0) begin
         blk_eff = BLOCK_BITS_W'(1);
      end else if (int'(block_bits_ff) > MAX_BLOCK_BITS) begin
         blk_eff = BLOCK_BITS_W'(MAX_BLOCK_BITS);
      end else begin
         blk_eff = block_bits_ff;
      end
      for (int i = 0; i < MAX_SET_BITS; i++) begin
         set_mask[i] = (i < int'(set_eff));
      end
      for (int w = 0; w < WAYS; w++) begin
         use_mask[w] = (w == 0) || (int'(ways_use_ff) > w);
      end
   end

   assign tag_shift = SHIFT_W'(set_eff) + SHIFT_W'(blk_eff);
   assign addr_blk  = a_addr_ff >> blk_eff;
   assign set_a     = addr_blk[MAX_SET_BITS-1:0] & set_mask;
   assign tag_a     = TAG_W'(a_addr_ff >> tag_shift);

   // pipeline control
   assign is_data    = (req_tuser == KIND_LOAD) || (req_tuser == KIND_STORE);
   assign c_ready    = !rsp_valid_ff || rsp_tready;
   assign b_ready    = !b_valid_ff || c_ready;
   assign b_write    = b_valid_ff && c_ready;
   assign a_move     = a_valid_ff && b_ready;
   assign req_tready = (!a_valid_ff || b_ready) && !clearing_ff;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      if (accept) begin
         a_valid_in = is_data;
      end else if (a_move) begin
         a_valid_in = 1'b0;
      end else begin
         a_valid_in = a_valid_ff;
      end
      if (a_move) begin
         b_valid_in = 1'b1;
      end else if (b_write) begin
         b_valid_in = 1'b0;
      end else begin
         b_valid_in = b_valid_ff;
      end
      if (b_write) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      fwd_sel_in  = b_write && (b_set_ff == set_a);
      clearing_in = clearing_ff && (clr_idx_ff != '1);
      clr_idx_in  = clearing_ff ? clr_idx_ff + 1'b1 : clr_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= SET_BITS_RST;
         block_bits_ff <= BLOCK_BITS_RST;
         ways_use_ff   <= WAYS_IN_USE_RST;
         clearing_ff   <= 1'b1;
         clr_idx_ff    <= '0;
         a_valid_ff    <= 1'b0;
         b_valid_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         set_bits_ff   <= set_bits_in;
         block_bits_ff <= block_bits_in;
         ways_use_ff   <= ways_use_in;
         clearing_ff   <= clearing_in;
         clr_idx_ff    <= clr_idx_in;
         a_valid_ff    <= a_valid_in;
         b_valid_ff    <= b_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_addr_ff  <= req_tdata;
         a_store_ff <= (req_tuser == KIND_STORE);
      end
      if (a_move) begin
         b_tag_ff     <= tag_a;
         b_set_ff     <= set_a;
         b_store_ff   <= a_store_ff;
         fwd_sel_ff   <= fwd_sel_in;
         fwd_valid_ff <= new_valid;
         fwd_tag_ff   <= new_tag;
         fwd_rank_ff  <= new_rank;
      end
      if (b_write) begin
         rsp_res_ff   <= result;
         rsp_store_ff <= b_store_ff;
      end
   end

   // set memory
   assign mem_we   = clearing_ff || b_write;
   assign wr_set   = clearing_ff ? clr_idx_ff : b_set_ff;
   assign wr_valid = clearing_ff ? '0 : new_valid;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_valid[wr_set] <= wr_valid;
         mem_tag[wr_set]   <= new_tag;
         mem_rank[wr_set]  <= new_rank;
      end
      if (a_move) begin
         rd_valid_ff <= mem_valid[set_a];
         rd_tag_ff   <= mem_tag[set_a];
         rd_rank_ff  <= mem_rank[set_a];
      end
   end

   assign row_valid = fwd_sel_ff ? fwd_valid_ff : rd_valid_ff;
   assign row_tag   = fwd_sel_ff ? fwd_tag_ff   : rd_tag_ff;
   assign row_rank  = fwd_sel_ff ? fwd_rank_ff  : rd_rank_ff;

   salc_lookup #(
      .WAYS (WAYS)
   ) u_lookup (
      .use_mask  (use_mask),
      .tag       (b_tag_ff),
      .row_valid (row_valid),
      .row_tag   (row_tag),
      .row_rank  (row_rank),
      .result    (result),
      .new_valid (new_valid),
      .new_tag   (new_tag),
      .new_rank  (new_rank)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - 2 - OUT_WAY_W){1'b0}},
                        rsp_res_ff.way, rsp_res_ff.evicted, rsp_res_ff.hit};
   assign rsp_tuser  = rsp_store_ff;

`ifndef ASSERT_OFF
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !a_valid_ff && !b_valid_ff && !rsp_valid_ff)
      else $error("pipeline busy during clearing pass");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]))
      else $error("result both hit and evicted");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(b_valid_ff))
      else $error("result word without lookup stage");

   a_b_hold: assert property (@(posedge clock) disable iff (reset)
      $past(b_valid_ff && !c_ready) |-> b_valid_ff && $stable(b_set_ff))
      else $error("stalled lookup stage lost its set");
`endif

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb
// Self-checking bench for the set-associative LRU cache lookup core. A short
// stimulus table opens the run; random phases follow, each under new lookup
// settings, with address streams kept to a few tags and sets so that hits,
// fills and evictions all occur. A local model of the sets predicts the result
// words the table does not give; each result is checked in order as it arrives.
// -----------------------------------------------------------------------------
module tb;
   import salc_pkg::*;

   localparam int MAX_SET_BITS_P = 8;
   localparam int WAYS_P         = 4;
   localparam int NUM_LINES      = (1 << MAX_SET_BITS_P) * WAYS_P;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int FLUSH_CYCLES   = 8;
   localparam int PHASES         = 12;
   localparam int FIXED_PHASES   = 10;
   localparam int WORDS_PER_PHASE = 120;
   localparam int TAG_POOL_N     = 6;
   localparam int STIM_ROWS      = 20;

   localparam logic [KIND_W-1:0]      KIND_FETCH = 2'd2;
   localparam logic [KIND_W-1:0]      KIND_SPARE = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_LONG
   } stall_mode_type;

   typedef struct packed {
      logic                 hit;
      logic                 evicted;
      logic [OUT_WAY_W-1:0] way;
      logic                 is_store;
   } outcome_type;

   typedef struct packed {
      logic        typed;
      outcome_type outcome;
   } access_note_type;

   typedef struct {
      logic [KIND_W-1:0]    kind;
      logic [ADDR_W-1:0]    addr;
      bit                   typed;
      bit                   hit;
      bit                   evicted;
      logic [OUT_WAY_W-1:0] way;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [ADDR_W-1:0]      req_tdata = '0;
   logic [KIND_W-1:0]      req_tuser = KIND_LOAD;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_SET_BITS;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // model of the sets
   bit                line_valid [NUM_LINES];
   logic [ADDR_W-1:0] line_tag   [NUM_LINES];
   int unsigned       line_rank  [NUM_LINES];
   logic [SET_BITS_W-1:0]   set_bits_cfg    = SET_BITS_RST;
   logic [BLOCK_BITS_W-1:0] block_bits_cfg  = BLOCK_BITS_RST;
   logic [WAYS_USE_W-1:0]   ways_cfg        = WAYS_IN_USE_RST;

   access_note_type access_notes [$];
   outcome_type     outcome_q [$];
   logic [ADDR_W-1:0] tag_pool [TAG_POOL_N];
   int             fail_count  = 0;
   int             cycle_count = 0;
   stall_mode_type stall_mode  = STALL_NONE;
   int unsigned    stretch_left = 0;

   stim_row_type stim_rows [STIM_ROWS] = '{
      '{KIND_LOAD,  64'h0000_0000_0000_0000, 1'b1, 1'b0, 1'b0, 2'd0},
      '{KIND_STORE, 64'h0000_0000_0000_000F, 1'b1, 1'b1, 1'b0, 2'd0},
      '{KIND_FETCH, 64'h0000_0000_0000_0100, 1'b0, 1'b0, 1'b0, 2'd0},
      '{KIND_SPARE, 64'h0000_0000_0000_0200, 1'b0, 1'b0, 1'b0, 2'd0},
      '{KIND_LOAD,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0, 2'd0},
      '{KIND_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b0, 2'd0},
      '{KIND_STORE, 64'h0000_0000_0000_0100, 1'b1, 1'b0, 1'b0, 2'd1},
      '{KIND_LOAD,  64'h0000_0000_0000_0200, 1'b1, 1'b0, 1'b0, 2'd2},
      '{KIND_LOAD,  64'h0000_0000_0000_0300, 1'b1, 1'b0, 1'b0, 2'd3},
      '{KIND_LOAD,  64'h0000_0000_0000_0400, 1'b1, 1'b0, 1'b1, 2'd0},
      '{KIND_LOAD,  64'h0000_0000_0000_0100, 1'b0, 1'b0, 1'b0, 2'd0},
      '{KIND_LOAD,  64'h0000_0000_0000_0500, 1'b0, 1'b0, 1'b0, 2'd0},
      '{KIND_STORE, 64'h8000_0000_0000_0010, 1'b1, 1'b0, 1'b0, 2'd0},
      '{KIND_LOAD,  64'h5555_5555_5555_5555, 1'b1, 1'b0, 1'b0, 2'd0},
      '{KIND_STORE, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b0, 1'b0, 2'd0},
      '{KIND_FETCH, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0, 2'd0},
      '{KIND_SPARE, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 1'b0, 2'd0},
      '{KIND_LOAD,  64'h0000_0000_0000_00F0, 1'b0, 1'b0, 1'b0, 2'd0},
      '{KIND_STORE, 64'h0000_0000_0000_0200, 1'b0, 1'b0, 1'b0, 2'd0},
      '{KIND_LOAD,  64'h7FFF_FFFF_FFFF_FFF0, 1'b0, 1'b0, 1'b0, 2'd0}
   };

   logic [CSR_DATA_W-1:0] phase_set_bits   [FIXED_PHASES] =
      '{5'd4, 5'd4, 5'd0, 5'd15, 5'd1, 5'd8,  5'd9,  5'd2, 5'd2, 5'd2};
   logic [CSR_DATA_W-1:0] phase_block_bits [FIXED_PHASES] =
      '{5'd4, 5'd4, 5'd0, 5'd31, 5'd1, 5'd16, 5'd17, 5'd3, 5'd3, 5'd3};
   logic [CSR_DATA_W-1:0] phase_ways       [FIXED_PHASES] =
      '{5'd1, 5'd4, 5'd0, 5'd7,  5'd2, 5'd4,  5'd5,  5'd3, 5'd1, 5'd4};

   set_assoc_lru_cache_lookup_core #(
      .MAX_SET_BITS (MAX_SET_BITS_P),
      .WAYS         (WAYS_P)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int unsigned clamp_field(input int unsigned v, input int unsigned lo,
                                               input int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // make way w the most recent; valid ways younger than older age by one
   function automatic void age_set(input int unsigned base, input int unsigned n,
                                   input int unsigned w, input int unsigned older);
      for (int unsigned v = 0; v < n; v++) begin
         if (v != w && line_valid[base + v] && line_rank[base + v] < older &&
             line_rank[base + v] < WAYS_P - 1)
            line_rank[base + v]++;
      end
      line_rank[base + w] = 0;
   endfunction

   function automatic void predict_lookup(input logic [KIND_W-1:0] kind,
                                          input logic [ADDR_W-1:0] addr,
                                          output bit produces, output outcome_type res);
      int unsigned s, b, n, base, pick, best;
      logic [ADDR_W-1:0] tag, set_idx;
      bit hit, found;
      res = '0;
      produces = 1'b0;
      if (kind != KIND_LOAD && kind != KIND_STORE) return;
      s = clamp_field(32'(set_bits_cfg), 1, MAX_SET_BITS_P);
      b = clamp_field(32'(block_bits_cfg), 1, MAX_BLOCK_BITS);
      n = clamp_field(32'(ways_cfg), 1, WAYS_P);
      tag = addr >> (s + b);
      set_idx = (addr >> b) & ((64'd1 << s) - 64'd1);
      base = 32'(set_idx[MAX_SET_BITS_P-1:0]) * WAYS_P;
      hit = 1'b0;
      found = 1'b0;
      pick = 0;
      for (int unsigned w = 0; w < n; w++) begin
         if (!hit && line_valid[base + w] && line_tag[base + w] == tag) begin
            hit = 1'b1;
            pick = w;
         end
      end
      if (hit) begin
         age_set(base, n, pick, line_rank[base + pick]);
      end else begin
         for (int unsigned w = 0; w < n; w++) begin
            if (!found && !line_valid[base + w]) begin
               found = 1'b1;
               pick = w;
            end
         end
         if (!found) begin
            best = 0;
            for (int unsigned w = 0; w < n; w++) begin
               if (line_rank[base + w] > best) begin
                  best = line_rank[base + w];
                  pick = w;
               end
            end
         end
         line_valid[base + pick] = 1'b1;
         line_tag[base + pick] = tag;
         age_set(base, n, pick, WAYS_P);
      end
      res.hit = hit;
      res.evicted = !hit && !found;
      res.way = pick[OUT_WAY_W-1:0];
      res.is_store = kind[0];
      produces = 1'b1;
   endfunction

   // few tags and few sets, so the stream keeps hitting and evicting
   function automatic logic [ADDR_W-1:0] make_address(input int unsigned s,
                                                      input int unsigned b);
      logic [ADDR_W-1:0] noise, tag, set_idx;
      noise = {$urandom, $urandom};
      if ($urandom_range(0, 99) < 8) return noise;
      tag = tag_pool[$urandom_range(0, TAG_POOL_N - 1)];
      set_idx = ($urandom_range(0, 9) == 0) ? (noise >> 40) : 64'($urandom_range(0, 2));
      return (tag << (s + b)) | ((set_idx & ((64'd1 << s) - 64'd1)) << b) |
             (noise & ((64'd1 << b) - 64'd1));
   endfunction

   task automatic check_field(input string name, input logic [3:0] exp_v,
                              input logic [3:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, act_v);
         fail_count++;
      end
   endtask

   task automatic put_access(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] addr,
                             input access_note_type note);
      access_notes.push_back(note);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= addr;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic put_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic write_settings(input logic [CSR_DATA_W-1:0] sb,
                                 input logic [CSR_DATA_W-1:0] bb,
                                 input logic [CSR_DATA_W-1:0] wb);
      put_csr(CSR_SET_BITS, sb);
      put_csr(CSR_BLOCK_BITS, bb);
      put_csr(CSR_WAYS_IN_USE, wb);
      put_csr(CSR_UNUSED, CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   // hold off until every word has come back and the pipe is empty
   task automatic settle();
      req_tvalid <= 1'b0;
      while (access_notes.size() != 0 || outcome_q.size() != 0) @(posedge clock);
      repeat (FLUSH_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (stretch_left == 0) begin
         stall_mode   <= stall_mode_type'($urandom_range(0, 3));
         stretch_left <= $urandom_range(16, 200);
      end else begin
         stretch_left <= stretch_left - 1;
      end
      case (stall_mode)
         STALL_NONE:  rsp_tready <= 1'b1;
         STALL_LIGHT: rsp_tready <= ($urandom_range(0, 3) != 0);
         STALL_HEAVY: rsp_tready <= ($urandom_range(0, 3) == 0);
         default:     rsp_tready <= (stretch_left[3:0] >= 4'd12);
      endcase
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      access_note_type note;
      outcome_type     res, exp_r;
      bit              produces;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SET_BITS:    set_bits_cfg   = csr_data[SET_BITS_W-1:0];
               CSR_BLOCK_BITS:  block_bits_cfg = csr_data[BLOCK_BITS_W-1:0];
               CSR_WAYS_IN_USE: ways_cfg       = csr_data[WAYS_USE_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            note = (access_notes.size() != 0) ? access_notes.pop_front() : '0;
            predict_lookup(req_tuser, req_tdata, produces, res);
            if (produces) outcome_q.push_back(note.typed ? note.outcome : res);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (outcome_q.size() == 0) begin
               $display("%0t unexpected result word: expected none actual %0h/%0b",
                        $time, rsp_tdata, rsp_tuser);
               fail_count++;
            end else begin
               exp_r = outcome_q.pop_front();
               check_field("hit", {3'b0, exp_r.hit}, {3'b0, rsp_tdata[0]});
               check_field("evicted", {3'b0, exp_r.evicted}, {3'b0, rsp_tdata[1]});
               check_field("way", {2'b0, exp_r.way}, {2'b0, rsp_tdata[3:2]});
               check_field("pad", 4'h0, rsp_tdata[7:4]);
               check_field("is_store", {3'b0, exp_r.is_store}, {3'b0, rsp_tuser});
            end
         end
      end
   end

   initial begin
      access_note_type note;
      logic [KIND_W-1:0]     kind;
      logic [CSR_DATA_W-1:0] sb, bb, wb;
      int unsigned s_eff, b_eff, r, done, burst_left, gap, max_gap;
      tag_pool = '{64'd0, 64'd1, 64'd2, 64'd3, 64'h0123_4567_89AB_CDEF, '1};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i]) begin
         note.typed = stim_rows[i].typed;
         note.outcome = '{stim_rows[i].hit, stim_rows[i].evicted, stim_rows[i].way,
                          stim_rows[i].kind[0]};
         put_access(stim_rows[i].kind, stim_rows[i].addr, note);
      end
      settle();

      for (int p = 0; p < PHASES; p++) begin
         if (p < FIXED_PHASES) begin
            sb = phase_set_bits[p];
            bb = phase_block_bits[p];
            wb = phase_ways[p];
         end else begin
            sb = CSR_DATA_W'($urandom);
            bb = CSR_DATA_W'($urandom);
            wb = CSR_DATA_W'($urandom);
         end
         tag_pool[4] = {$urandom, $urandom};
         tag_pool[5] = {$urandom, $urandom};
         write_settings(sb, bb, wb);
         s_eff = clamp_field(32'(sb[SET_BITS_W-1:0]), 1, MAX_SET_BITS_P);
         b_eff = clamp_field(32'(bb), 1, MAX_BLOCK_BITS);
         max_gap = (p % 3 == 2) ? 0 : 6;
         burst_left = $urandom_range(1, 24);
         done = 0;
         while (done < WORDS_PER_PHASE) begin
            r = $urandom_range(0, 99);
            kind = (r < 46) ? KIND_LOAD : (r < 88) ? KIND_STORE :
                   (r < 95) ? KIND_FETCH : KIND_SPARE;
            put_access(kind, make_address(s_eff, b_eff), '0);
            if (kind == KIND_LOAD || kind == KIND_STORE) done++;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap = $urandom_range(0, max_gap);
               if (gap != 0) begin
                  req_tvalid <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
            end else begin
               burst_left--;
            end
         end
         settle();
      end

      if (fail_count == 0 && outcome_q.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

[sim.f]
rtl/salc_pkg.sv
rtl/salc_lookup.sv
rtl/set_assoc_lru_cache_lookup_core.sv
dv/tb.sv
